// ----- design/cpd_pkg.sv -----
package cpd_pkg;

   localparam int CANVAS_SIZE_DEFAULT = 128;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int OP_W        = 3;
   localparam int FIELD_W     = 8;
   localparam int CHAR_W      = 8;
   localparam int CFG_W       = 8;
   localparam int CSR_INDEX_W = 1;
   // signed coordinate math: covers x+len-1 up to 509, -1, and sizes up to 1024
   localparam int COORD_W     = 12;
   localparam int JOB_KIND_W  = 2;
   localparam int PIECE_W     = 2;
   localparam int RECT_PIECES = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0]  CFG_RESET  = 8'd128;
   localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

   typedef enum logic [OP_W-1:0] {
      OP_POINT = 3'd0,
      OP_HRUN  = 3'd1,
      OP_VRUN  = 3'd2,
      OP_RECT  = 3'd3,
      OP_CLEAR = 3'd4,
      OP_READ  = 3'd5
   } op_type;

   typedef enum logic [JOB_KIND_W-1:0] {
      JOB_H     = 2'd0,
      JOB_V     = 2'd1,
      JOB_CLEAR = 2'd2,
      JOB_READ  = 2'd3
   } job_kind_type;

   typedef enum logic [2:0] {
      BACK_INIT,
      BACK_IDLE,
      BACK_RUN,
      BACK_READ,
      BACK_REPLY
   } back_state_type;

   // queue entry: kind, ok flag, fixed / first / last index, character
   function automatic int entry_width(input int aw);
      return JOB_KIND_W + 1 + 3 * aw + CHAR_W;
   endfunction

endpackage

// ----- design/cpd_queue.sv -----
module cpd_queue #(
   parameter int DEPTH  = cpd_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty
);
   import cpd_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue push while full");

endmodule

// ----- design/cpd_front.sv -----
module cpd_front #(
   parameter  int CANVAS_SIZE = cpd_pkg::CANVAS_SIZE_DEFAULT,
   localparam int AW          = $clog2(CANVAS_SIZE),
   localparam int ENTRY_W     = cpd_pkg::entry_width(AW)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [cpd_pkg::OP_W-1:0]      req_operation,
   input  logic [cpd_pkg::FIELD_W-1:0]   req_x_pos,
   input  logic [cpd_pkg::FIELD_W-1:0]   req_y_pos,
   input  logic [cpd_pkg::FIELD_W-1:0]   req_span_length,
   input  logic [cpd_pkg::FIELD_W-1:0]   req_span_height,
   input  logic [cpd_pkg::CHAR_W-1:0]    req_draw_char,
   input  logic                          csr_we,
   input  logic [cpd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cpd_pkg::CFG_W-1:0]     csr_wdata,
   input  logic                          init_busy,
   output logic                          push,
   output logic [ENTRY_W-1:0]            push_data,
   input  logic                          full
);
   import cpd_pkg::*;

   typedef struct packed {
      job_kind_type      kind;
      logic              ok;
      logic [AW-1:0]     fixed;
      logic [AW-1:0]     first;
      logic [AW-1:0]     last;
      logic [CHAR_W-1:0] ch;
   } job_type;

   localparam logic signed [COORD_W-1:0] SIZE_C = COORD_W'(CANVAS_SIZE);

   logic               cmd_valid_ff, cmd_valid_in;
   logic [PIECE_W-1:0] piece_ff, piece_in;
   logic [OP_W-1:0]    op_ff;
   logic [FIELD_W-1:0] x_ff, y_ff, len_ff, hgt_ff;
   logic [CHAR_W-1:0]  ch_ff;
   logic [CFG_W-1:0]   width_ff, height_ff;

   logic signed [COORD_W-1:0] xs, ys, ls, hs;
   logic signed [COORD_W-1:0] fix_s, start_s, len_s, end_s, endc_s, last_s;
   logic signed [COORD_W-1:0] wc_s, hc_s, wm1_s, hm1_s;
   job_kind_type seg_kind;
   logic         seg_en, last_piece;
   job_type      job;
   logic         job_valid, advance, cmd_done, accept;

   assign xs = $signed(COORD_W'(x_ff));
   assign ys = $signed(COORD_W'(y_ff));
   assign ls = $signed(COORD_W'(len_ff));
   assign hs = $signed(COORD_W'(hgt_ff));

   // split each drawing command into straight runs
   always_comb begin
      seg_en   = 1'b0;
      seg_kind = JOB_H;
      fix_s    = ys;
      start_s  = xs;
      len_s    = ls;
      unique case (op_ff)
         OP_POINT: begin
            seg_en = 1'b1;
            len_s  = COORD_W'(1);
         end
         OP_HRUN: begin
            seg_en = 1'b1;
         end
         OP_VRUN: begin
            seg_en   = 1'b1;
            seg_kind = JOB_V;
            fix_s    = xs;
            start_s  = ys;
         end
         OP_RECT: begin
            seg_en = 1'b1;
            unique case (piece_ff)
               2'd0: begin
               end
               2'd1: begin
                  fix_s = ys + hs - COORD_W'(1);
               end
               2'd2: begin
                  seg_kind = JOB_V;
                  fix_s    = xs;
                  start_s  = ys;
                  len_s    = hs;
               end
               default: begin
                  seg_kind = JOB_V;
                  fix_s    = xs + ls - COORD_W'(1);
                  start_s  = ys;
                  len_s    = hs;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // clip to the store and build the queue entry
   always_comb begin
      end_s  = start_s + len_s;
      endc_s = (end_s > SIZE_C) ? SIZE_C : end_s;
      last_s = endc_s - COORD_W'(1);
      wc_s   = ($signed(COORD_W'(width_ff)) > SIZE_C) ? SIZE_C : $signed(COORD_W'(width_ff));
      hc_s   = ($signed(COORD_W'(height_ff)) > SIZE_C) ? SIZE_C : $signed(COORD_W'(height_ff));
      wm1_s  = wc_s - COORD_W'(1);
      hm1_s  = hc_s - COORD_W'(1);

      job.kind  = seg_kind;
      job.ok    = 1'b1;
      job.fixed = fix_s[AW-1:0];
      job.first = start_s[AW-1:0];
      job.last  = last_s[AW-1:0];
      job.ch    = ch_ff;
      job_valid = seg_en && (start_s < endc_s) && (fix_s >= 0) && (fix_s < SIZE_C);

      if (op_ff == OP_CLEAR) begin
         job.kind  = JOB_CLEAR;
         job.fixed = hm1_s[AW-1:0];
         job.first = '0;
         job.last  = wm1_s[AW-1:0];
         job.ch    = SPACE_CHAR;
         job_valid = (wc_s != 0) && (hc_s != 0);
      end else if (op_ff == OP_READ) begin
         job.kind  = JOB_READ;
         job.ok    = (xs < SIZE_C) && (ys < SIZE_C);
         job.fixed = ys[AW-1:0];
         job.first = xs[AW-1:0];
         job.last  = xs[AW-1:0];
         job_valid = 1'b1;
      end
   end

   assign last_piece = (op_ff == OP_RECT) ? (piece_ff == PIECE_W'(RECT_PIECES - 1)) : 1'b1;
   assign advance    = cmd_valid_ff && (!job_valid || !full);
   assign push       = cmd_valid_ff && job_valid && !full;
   assign push_data  = job;
   assign cmd_done   = advance && last_piece;
   assign busy       = init_busy || (cmd_valid_ff && !cmd_done);
   assign accept     = start && !busy;

   always_comb begin
      cmd_valid_in = cmd_valid_ff;
      piece_in     = piece_ff;
      if (accept) begin
         cmd_valid_in = 1'b1;
         piece_in     = '0;
      end else if (cmd_done) begin
         cmd_valid_in = 1'b0;
      end else if (advance) begin
         piece_in = piece_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         piece_ff     <= '0;
         width_ff     <= CFG_RESET;
         height_ff    <= CFG_RESET;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         piece_ff     <= piece_in;
         if (csr_we && csr_index == CSR_WIDTH) begin
            width_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_HEIGHT) begin
            height_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_operation;
         x_ff   <= req_x_pos;
         y_ff   <= req_y_pos;
         len_ff <= req_span_length;
         hgt_ff <= req_span_height;
         ch_ff  <= req_draw_char;
      end
   end

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> cmd_valid_ff)
      else $error("accepted command not held");

endmodule

// ----- design/cpd_back.sv -----
module cpd_back #(
   parameter  int CANVAS_SIZE = cpd_pkg::CANVAS_SIZE_DEFAULT,
   localparam int AW          = $clog2(CANVAS_SIZE),
   localparam int ENTRY_W     = cpd_pkg::entry_width(AW)
) (
   input  logic                       clock,
   input  logic                       reset,
   output logic                       pop,
   input  logic [ENTRY_W-1:0]         pop_data,
   input  logic                       empty,
   output logic                       init_busy,
   output logic                       rsp_strobe,
   output logic [cpd_pkg::CHAR_W-1:0] rsp_cell_char
);
   import cpd_pkg::*;

   typedef struct packed {
      job_kind_type      kind;
      logic              ok;
      logic [AW-1:0]     fixed;
      logic [AW-1:0]     first;
      logic [AW-1:0]     last;
      logic [CHAR_W-1:0] ch;
   } job_type;

   localparam int DEPTH_C = CANVAS_SIZE * CANVAS_SIZE;
   localparam int MAW     = $clog2(DEPTH_C);

   logic [CHAR_W-1:0] mem [DEPTH_C];

   back_state_type    state_ff, state_in;
   job_type           job_ff, job_in, entry;
   logic [MAW-1:0]    addr_ff, addr_in;
   logic [MAW-1:0]    row_base_ff, row_base_in;
   logic [AW-1:0]     cursor_ff, cursor_in;
   logic [AW-1:0]     row_ff, row_in;
   logic [CHAR_W-1:0] rdata_ff;
   logic              we, re;
   logic [CHAR_W-1:0] wdata;

   assign entry = job_type'(pop_data);

   always_comb begin
      state_in    = state_ff;
      job_in      = job_ff;
      addr_in     = addr_ff;
      row_base_in = row_base_ff;
      cursor_in   = cursor_ff;
      row_in      = row_ff;
      pop         = 1'b0;
      we          = 1'b0;
      re          = 1'b0;
      wdata       = job_ff.ch;
      rsp_strobe  = 1'b0;
      unique case (state_ff)
         BACK_INIT: begin
            we    = 1'b1;
            wdata = SPACE_CHAR;
            if (addr_ff == MAW'(DEPTH_C - 1)) begin
               state_in = BACK_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         BACK_IDLE: begin
            if (!empty) begin
               pop         = 1'b1;
               job_in      = entry;
               cursor_in   = entry.first;
               row_in      = '0;
               row_base_in = '0;
               state_in    = (entry.kind == JOB_READ) ? BACK_READ : BACK_RUN;
               unique case (entry.kind)
                  JOB_V: begin
                     addr_in = MAW'(entry.first) * MAW'(CANVAS_SIZE) + MAW'(entry.fixed);
                  end
                  JOB_CLEAR: begin
                     addr_in = '0;
                  end
                  default: begin
                     addr_in = MAW'(entry.fixed) * MAW'(CANVAS_SIZE) + MAW'(entry.first);
                  end
               endcase
            end
         end
         BACK_RUN: begin
            we = 1'b1;
            if (cursor_ff == job_ff.last) begin
               if (job_ff.kind == JOB_CLEAR && row_ff != job_ff.fixed) begin
                  row_in      = row_ff + 1'b1;
                  cursor_in   = job_ff.first;
                  row_base_in = row_base_ff + MAW'(CANVAS_SIZE);
                  addr_in     = row_base_ff + MAW'(CANVAS_SIZE);
               end else begin
                  state_in = BACK_IDLE;
               end
            end else begin
               cursor_in = cursor_ff + 1'b1;
               addr_in   = (job_ff.kind == JOB_V) ? addr_ff + MAW'(CANVAS_SIZE)
                                                  : addr_ff + 1'b1;
            end
         end
         BACK_READ: begin
            re       = job_ff.ok;
            state_in = BACK_REPLY;
         end
         BACK_REPLY: begin
            rsp_strobe = 1'b1;
            state_in   = BACK_IDLE;
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   assign init_busy     = (state_ff == BACK_INIT);
   assign rsp_cell_char = job_ff.ok ? rdata_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_INIT;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      row_base_ff <= row_base_in;
      cursor_ff   <= cursor_in;
      row_ff      <= row_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr_ff] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr_ff];
      end
   end

   a_reply_after_read: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == BACK_READ)
      else $error("response strobe without a read");

   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_RUN) |-> cursor_ff <= job_ff.last)
      else $error("run cursor past last cell");

   a_no_pop_in_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_INIT) |=> !pop || $past(addr_ff) == MAW'(DEPTH_C - 1))
      else $error("job taken during clearing pass");

endmodule

// ----- design/canvas_primitive_drawer_top.sv -----
// Channel   Ports                                   Transfer
// -------   -------------------------------------   ---------------------------------
// command   start, busy, req_*                      edge with start=1 and busy=0
// result    rsp_strobe, rsp_cell_char               edge ending a strobe cycle
// config    csr_we, csr_index, csr_wdata            edge with csr_we=1
//
// Cycles: one cell write per cycle; a command is registered in the front, pushed into the queue
// and popped by the back once it is idle; a run or a clear then sweeps its clipped cells, while a
// read loads the cell in a read state and then raises the strobe in a reply state.
// Reset: a clearing pass writes spaces into all cells; busy stays high until it ends.
// Stalls: busy rises while the queue is full or a rectangle is split; no receiver stall.
module canvas_primitive_drawer_top #(
   parameter int CANVAS_SIZE = cpd_pkg::CANVAS_SIZE_DEFAULT,
   parameter int QUEUE_DEPTH = cpd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [cpd_pkg::OP_W-1:0]        req_operation,
   input  logic [cpd_pkg::FIELD_W-1:0]     req_x_pos,
   input  logic [cpd_pkg::FIELD_W-1:0]     req_y_pos,
   input  logic [cpd_pkg::FIELD_W-1:0]     req_span_length,
   input  logic [cpd_pkg::FIELD_W-1:0]     req_span_height,
   input  logic [cpd_pkg::CHAR_W-1:0]      req_draw_char,
   output logic                            rsp_strobe,
   output logic [cpd_pkg::CHAR_W-1:0]      rsp_cell_char,
   input  logic                            csr_we,
   input  logic [cpd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cpd_pkg::CFG_W-1:0]       csr_wdata
);
   import cpd_pkg::*;

   localparam int AW      = $clog2(CANVAS_SIZE);
   localparam int ENTRY_W = entry_width(AW);

   // front to queue
   logic               push, full;
   logic [ENTRY_W-1:0] push_data;
   // queue to back
   logic               pop, empty;
   logic [ENTRY_W-1:0] pop_data;
   // back status: clearing pass still running
   logic               init_busy;

   // front: takes commands, holds the clear extent, splits shapes into clipped runs
   cpd_front #(
      .CANVAS_SIZE(CANVAS_SIZE)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_x_pos      (req_x_pos),
      .req_y_pos      (req_y_pos),
      .req_span_length(req_span_length),
      .req_span_height(req_span_height),
      .req_draw_char  (req_draw_char),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .init_busy      (init_busy),
      .push           (push),
      .push_data      (push_data),
      .full           (full)
   );

   // short job queue decouples command intake from memory sweeps
   cpd_queue #(
      .DEPTH (QUEUE_DEPTH),
      .DATA_W(ENTRY_W)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .full     (full),
      .pop      (pop),
      .pop_data (pop_data),
      .empty    (empty)
   );

   // back: owns the canvas memory, sweeps runs and clears, answers reads
   cpd_back #(
      .CANVAS_SIZE(CANVAS_SIZE)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .pop          (pop),
      .pop_data     (pop_data),
      .empty        (empty),
      .init_busy    (init_busy),
      .rsp_strobe   (rsp_strobe),
      .rsp_cell_char(rsp_cell_char)
   );

endmodule
